### hw/rtl/dpr_pkg.sv
// dpr_pkg: shared types, codes and helpers for the debug packet receiver.
// No dependencies; imported by every module of the block.
package dpr_pkg;

    localparam logic [7:0] START_BYTE  = 8'h24;
    localparam logic [7:0] HASH_BYTE   = 8'h23;
    localparam logic [7:0] ESC_XOR     = 8'h20;
    localparam logic [7:0] ESCAPE_RST  = 8'd125;

    localparam logic [2:0] PH_HUNT = 3'd0;
    localparam logic [2:0] PH_DATA = 3'd1;
    localparam logic [2:0] PH_ESC  = 3'd2;
    localparam logic [2:0] PH_HI   = 3'd3;
    localparam logic [2:0] PH_LO   = 3'd4;

    localparam logic [1:0] ST_DATA     = 2'd0;
    localparam logic [1:0] ST_ACK      = 2'd1;
    localparam logic [1:0] ST_NACK     = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    localparam int TDATA_W = 48;

    typedef struct packed {
        logic [2:0] phase;
        logic [7:0] running_sum;
        logic [3:0] high_digit;
    } dpr_state_t;

    typedef struct packed {
        logic        valid;
        logic [1:0]  status;
        logic [7:0]  payload_byte;
        logic [9:0]  byte_index;
        logic [10:0] payload_length;
        logic [7:0]  received_sum;
        logic [7:0]  computed_sum;
    } dpr_result_t;

    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            v = c[3:0];
        end
        else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
        begin
            v = c[3:0] + 4'd9;
        end
        return v;
    endfunction

endpackage

### hw/rtl/debug_packet_receiver_unit.sv
// debug_packet_receiver_unit: '$' payload '#' hh packet deframer, top level.
// Depends on dpr_pkg and dpr_decode.
//
// One received byte per item, one item per cycle when the output side is
// ready. A byte is taken into an input register, then decoded by one
// pass of the packet state machine and checksum adder once the output
// register can advance; its result (if any) lands in the output register.
// Payload bytes are reported with their index; the packet end reports ack
// or nack with length and both sums, or overflow with length and the
// computed sum.
// The escape code may only be changed while the block is idle.
module debug_packet_receiver_unit #(
    parameter int MAX_PAYLOAD = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,       // escape_code
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,    // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] payload_byte, [17:8] byte_index, [28:18] payload_length,
    // [36:29] received_sum, [44:37] computed_sum, [47:45] zero
    output logic [47:0] m_axis_tdata,
    output logic [1:0]  m_axis_tuser     // [1:0] status
);
    import dpr_pkg::*;

    localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);

    logic             in_valid_reg;
    logic [7:0]       in_byte_reg;
    logic [7:0]       escape_reg;
    dpr_state_t       state_reg;
    dpr_state_t       state_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    dpr_result_t      result_next;
    logic             out_valid_reg;
    dpr_result_t      out_res_reg;
    logic             advance;

    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || advance;

    dpr_decode #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .CNT_W       (CNT_W)
    ) u_decode (
        .state       (state_reg),
        .count       (count_reg),
        .rx_byte     (in_byte_reg),
        .escape_code (escape_reg),
        .state_next  (state_next),
        .count_next  (count_next),
        .result      (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            escape_reg    <= ESCAPE_RST;
            state_reg     <= '{phase: PH_HUNT, running_sum: 8'd0, high_digit: 4'd0};
            count_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                escape_reg <= cfg_wdata;
            end
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg && result_next.valid;
                if (in_valid_reg)
                begin
                    state_reg <= state_next;
                    count_reg <= count_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg <= s_axis_tdata;
        end
        if (advance && in_valid_reg && result_next.valid)
        begin
            out_res_reg <= result_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_res_reg.status;
    assign m_axis_tdata  = {3'b000,
                            out_res_reg.computed_sum,
                            out_res_reg.received_sum,
                            out_res_reg.payload_length,
                            out_res_reg.byte_index,
                            out_res_reg.payload_byte};

endmodule

### hw/rtl/dpr_decode.sv
// dpr_decode: next-state and result logic for one received byte.
// Depends on dpr_pkg.
module dpr_decode #(
    parameter int MAX_PAYLOAD = 1024,
    parameter int CNT_W       = 11
) (
    input  dpr_pkg::dpr_state_t  state,
    input  logic [CNT_W-1:0]     count,
    input  logic [7:0]           rx_byte,
    input  logic [7:0]           escape_code,
    output dpr_pkg::dpr_state_t  state_next,
    output logic [CNT_W-1:0]     count_next,
    output dpr_pkg::dpr_result_t result
);
    import dpr_pkg::*;

    logic [7:0] sum_add;
    logic [7:0] rsum;

    assign sum_add = state.running_sum + rx_byte;
    assign rsum    = {state.high_digit, hex_value(rx_byte)};

    always_comb
    begin
        state_next = state;
        count_next = count;
        result     = '0;
        case (state.phase)
            PH_DATA:
            begin
                if (count >= CNT_W'(MAX_PAYLOAD))
                begin
                    result.valid          = 1'b1;
                    result.status         = ST_OVERFLOW;
                    result.payload_length = 11'(count);
                    result.computed_sum   = state.running_sum;
                    state_next.phase      = PH_HUNT;
                end
                else if (rx_byte == HASH_BYTE)
                begin
                    state_next.phase = PH_HI;
                end
                else
                begin
                    state_next.running_sum = sum_add;
                    if (rx_byte == escape_code)
                    begin
                        state_next.phase = PH_ESC;
                    end
                    else
                    begin
                        result.valid        = 1'b1;
                        result.status       = ST_DATA;
                        result.payload_byte = rx_byte;
                        result.byte_index   = 10'(count);
                        count_next          = count + 1'b1;
                    end
                end
            end
            PH_ESC:
            begin
                state_next.running_sum = sum_add;
                state_next.phase       = PH_DATA;
                result.valid           = 1'b1;
                result.status          = ST_DATA;
                result.payload_byte    = rx_byte ^ ESC_XOR;
                result.byte_index      = 10'(count);
                count_next             = count + 1'b1;
            end
            PH_HI:
            begin
                state_next.high_digit = hex_value(rx_byte);
                state_next.phase      = PH_LO;
            end
            PH_LO:
            begin
                result.valid          = 1'b1;
                result.status         = (rsum == state.running_sum) ? ST_ACK : ST_NACK;
                result.payload_length = 11'(count);
                result.received_sum   = rsum;
                result.computed_sum   = state.running_sum;
                state_next.phase      = PH_HUNT;
            end
            default:
            begin
                if (rx_byte == START_BYTE)
                begin
                    state_next.phase       = PH_DATA;
                    state_next.running_sum = 8'd0;
                    state_next.high_digit  = 4'd0;
                    count_next             = '0;
                end
                else
                begin
                    state_next.phase = PH_HUNT;
                end
            end
        endcase
    end

endmodule

### hw/rtl/dpr_checker.sv
// dpr_checker: port-level assertions for debug_packet_receiver_unit.
// Depends on dpr_pkg; bound to the top level below.
module dpr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);
    import dpr_pkg::*;

    // stalled item holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result item changed");

    a_data_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == ST_DATA |-> m_axis_tdata[47:18] == '0)
        else $error("payload item carries packet-end fields");

    a_end_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser != ST_DATA |-> m_axis_tdata[17:0] == '0)
        else $error("packet-end item carries payload fields");

    a_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == ST_ACK || m_axis_tuser == ST_NACK) |->
            ((m_axis_tdata[36:29] == m_axis_tdata[44:37]) == (m_axis_tuser == ST_ACK)))
        else $error("ack/nack disagrees with sums");

    a_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == ST_OVERFLOW |-> m_axis_tdata[36:29] == 8'd0)
        else $error("overflow item carries received sum");

endmodule

bind debug_packet_receiver_unit dpr_checker u_dpr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

### bench/debug_packet_receiver_unit_tb.sv
// Self-checking bench for debug_packet_receiver_unit: '$' payload '#' hh deframing.
// A byte stream goes in under random bursts and stalls; every result is checked against
// a built-in decoder. Depends on dpr_pkg and the block's RTL only.
`timescale 1ns / 1ps

module debug_packet_receiver_unit_tb;

    import dpr_pkg::*;

    localparam int CLK_PERIOD   = 4;
    localparam int PAYLOAD_CAP  = 1024;
    localparam int TIMEOUT_NS   = 400000 * CLK_PERIOD;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  pbyte;
        logic [9:0]  index;
        logic [10:0] length;
        logic [7:0]  rx_sum;
        logic [7:0]  calc_sum;
    } frame_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [7:0]  cfg_wdata = ESCAPE_RST;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;        // [7:0] rx_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;                // [7:0] byte, [17:8] index, [28:18] length,
                                              // [36:29] rx sum, [44:37] calc sum
    logic [1:0]  m_axis_tuser;                // [1:0] status

    // decoder state, mirrors the block
    logic [2:0]  dec_phase = PH_HUNT;
    logic [7:0]  dec_sum = 8'h00;
    logic [10:0] dec_count = 11'd0;
    logic [3:0]  dec_hi = 4'h0;
    logic [7:0]  esc_code = ESCAPE_RST;

    logic [7:0]    pending_bytes[$];
    frame_result_t expected_results[$];

    int bytes_queued = 0;
    int bytes_accepted = 0;
    int escape_writes = 0;
    int mismatches = 0;
    int status_seen[4] = '{0, 0, 0, 0};
    int burst_left = 0;
    int gap_left = 0;
    int rx_cycle = 0;
    int rx_mode = 0;

    debug_packet_receiver_unit #(
        .MAX_PAYLOAD(PAYLOAD_CAP)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser)
    );

    always
    begin
        #(CLK_PERIOD / 2) clk = 1'b1;
        #(CLK_PERIOD / 2) clk = 1'b0;
    end

    function automatic logic [3:0] nibble_of(input logic [7:0] c);
        logic [3:0] n;
        n = 4'h0;
        if (c >= "0" && c <= "9")
        begin
            n = 4'(c - "0");
        end
        else if (c >= "a" && c <= "f")
        begin
            n = 4'(c - "a" + 10);
        end
        else if (c >= "A" && c <= "F")
        begin
            n = 4'(c - "A" + 10);
        end
        return n;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        logic [7:0] c;
        if (n < 10)
        begin
            c = 8'("0") + 8'(n);
        end
        else
        begin
            c = ($urandom_range(0, 1) ? 8'("A") : 8'("a")) + 8'(n) - 8'd10;
        end
        return c;
    endfunction

    task automatic advance_deframer(input logic [7:0] b);
        frame_result_t r;
        bit            has_result;
        logic [7:0]    got_sum;
        r = '0;
        has_result = 1'b0;
        case (dec_phase)
            PH_DATA:
            begin
                if (dec_count >= PAYLOAD_CAP)
                begin
                    r.status = ST_OVERFLOW;
                    r.length = dec_count;
                    r.calc_sum = dec_sum;
                    has_result = 1'b1;
                    dec_phase = PH_HUNT;
                end
                else if (b == HASH_BYTE)
                begin
                    dec_phase = PH_HI;
                end
                else
                begin
                    dec_sum = dec_sum + b;
                    if (b == esc_code)
                    begin
                        dec_phase = PH_ESC;
                    end
                    else
                    begin
                        r.status = ST_DATA;
                        r.pbyte = b;
                        r.index = dec_count[9:0];
                        has_result = 1'b1;
                        dec_count = dec_count + 11'd1;
                    end
                end
            end
            PH_ESC:
            begin
                dec_sum = dec_sum + b;
                r.status = ST_DATA;
                r.pbyte = b ^ ESC_XOR;
                r.index = dec_count[9:0];
                has_result = 1'b1;
                dec_count = dec_count + 11'd1;
                dec_phase = PH_DATA;
            end
            PH_HI:
            begin
                dec_hi = nibble_of(b);
                dec_phase = PH_LO;
            end
            PH_LO:
            begin
                got_sum = {dec_hi, nibble_of(b)};
                r.status = (got_sum == dec_sum) ? ST_ACK : ST_NACK;
                r.length = dec_count;
                r.rx_sum = got_sum;
                r.calc_sum = dec_sum;
                has_result = 1'b1;
                dec_phase = PH_HUNT;
            end
            default:
            begin
                if (b == START_BYTE)
                begin
                    dec_phase = PH_DATA;
                    dec_sum = 8'h00;
                    dec_count = 11'd0;
                    dec_hi = 4'h0;
                end
            end
        endcase
        if (has_result)
        begin
            expected_results.push_back(r);
        end
    endtask

    task automatic flag_mismatch(input string what, input int got, input int want);
        mismatches++;
        $display("%0t: %s mismatch, got %0h want %0h", $realtime, what, got, want);
    endtask

    // sender: bursts of random length, random gaps between them
    always @(posedge clk or negedge rst_n)
    begin : drive_proc
        logic       nxt_valid;
        logic [7:0] nxt_data;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= 8'h00;
        end
        else
        begin
            nxt_valid = s_axis_tvalid;
            nxt_data = s_axis_tdata;
            if (s_axis_tvalid && s_axis_tready)
            begin
                advance_deframer(s_axis_tdata);
                bytes_accepted++;
                nxt_valid = 1'b0;
            end
            if (!nxt_valid)
            begin
                if (gap_left != 0)
                begin
                    gap_left--;
                end
                else if (pending_bytes.size() != 0)
                begin
                    nxt_valid = 1'b1;
                    nxt_data = pending_bytes.pop_front();
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0;
                    end
                    else
                    begin
                        burst_left--;
                    end
                end
            end
            s_axis_tvalid <= nxt_valid;
            s_axis_tdata <= nxt_data;
        end
    end

    // receiver: ready pattern from a randomly re-picked mode, long hold-off in a fixed window
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (rx_cycle % 64 == 0)
            begin
                rx_mode = $urandom_range(0, 3);
            end
            if (rx_cycle % 2048 >= 1000 && rx_cycle % 2048 < 1400)
            begin
                m_axis_tready <= 1'b0;
            end
            else
            begin
                case (rx_mode)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= 1'($urandom_range(0, 1));
                    2: m_axis_tready <= ($urandom_range(0, 3) == 0);
                    default: m_axis_tready <= ($urandom_range(0, 3) != 0);
                endcase
            end
            rx_cycle++;
        end
    end

    always @(posedge clk)
    begin : check_proc
        frame_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_results.size() == 0)
            begin
                flag_mismatch("unexpected item, status", m_axis_tuser, 0);
            end
            else
            begin
                want = expected_results.pop_front();
                status_seen[want.status]++;
                if (m_axis_tuser !== want.status)
                    flag_mismatch("status", m_axis_tuser, want.status);
                if (m_axis_tdata[7:0] !== want.pbyte)
                    flag_mismatch("payload_byte", m_axis_tdata[7:0], want.pbyte);
                if (m_axis_tdata[17:8] !== want.index)
                    flag_mismatch("byte_index", m_axis_tdata[17:8], want.index);
                if (m_axis_tdata[28:18] !== want.length)
                    flag_mismatch("payload_length", m_axis_tdata[28:18], want.length);
                if (m_axis_tdata[36:29] !== want.rx_sum)
                    flag_mismatch("received_sum", m_axis_tdata[36:29], want.rx_sum);
                if (m_axis_tdata[44:37] !== want.calc_sum)
                    flag_mismatch("computed_sum", m_axis_tdata[44:37], want.calc_sum);
                if (m_axis_tdata[47:45] !== 3'b000)
                    flag_mismatch("tdata padding", m_axis_tdata[47:45], 0);
            end
        end
    end

    task automatic queue_byte(input logic [7:0] b);
        pending_bytes.push_back(b);
        bytes_queued++;
    endtask

    // '$', n decoded bytes (escaped where needed or at random), optionally '#' hh
    task automatic send_packet(input int n_data, input int esc_pct, input bit bad_sum,
                               input bit close);
        logic [7:0] sum;
        logic [7:0] d;
        logic [7:0] chk;
        sum = 8'h00;
        queue_byte(START_BYTE);
        for (int i = 0; i < n_data; i++)
        begin
            d = 8'($urandom_range(0, 255));
            if (d == HASH_BYTE || d == esc_code || $urandom_range(0, 99) < esc_pct)
            begin
                queue_byte(esc_code);
                sum = sum + esc_code;
                d = d ^ ESC_XOR;
            end
            queue_byte(d);
            sum = sum + d;
        end
        if (close)
        begin
            chk = bad_sum ? (sum ^ 8'($urandom_range(1, 255))) : sum;
            queue_byte(HASH_BYTE);
            queue_byte(hex_char(chk[7:4]));
            queue_byte(hex_char(chk[3:0]));
        end
    endtask

    task automatic random_traffic(input int n);
        int first;
        int pick;
        first = bytes_queued;
        while (bytes_queued - first < n)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 7)
            begin
                if ($urandom_range(0, 3) == 0)
                    queue_byte(8'($urandom_range(0, 255)));
                send_packet(($urandom_range(0, 9) == 0) ? $urandom_range(13, 60)
                                                        : $urandom_range(0, 12),
                            10, ($urandom_range(0, 4) == 0), 1'b1);
            end
            else if (pick == 7)
            begin
                repeat ($urandom_range(1, 5))
                    queue_byte(8'($urandom_range(0, 255)));
            end
            else if (pick == 8)
            begin
                send_packet($urandom_range(0, 8), 10, 1'b0, 1'b0);
                repeat ($urandom_range(0, 3))
                    queue_byte(8'($urandom_range(0, 255)));
            end
            else
            begin
                send_packet($urandom_range(0, 6), 10, 1'b0, 1'b0);
                queue_byte(HASH_BYTE);
                queue_byte(8'($urandom_range(0, 255)));
                queue_byte(8'($urandom_range(0, 255)));
            end
        end
    endtask

    // sender waits until every expected result is back, then allows for latency
    task automatic drain();
        while (pending_bytes.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_escape(input logic [7:0] v);
        drain();
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        esc_code = v;
        escape_writes++;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin : stimulus
        logic [7:0] s;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed, reset escape code
        queue_byte(8'h00);
        queue_byte(8'hFF);
        // escape then '#' is data; '$' inside payload is data
        s = 8'h00 + 8'hFF + ESCAPE_RST + HASH_BYTE + START_BYTE;
        queue_byte(START_BYTE);
        queue_byte(8'h00);
        queue_byte(8'hFF);
        queue_byte(ESCAPE_RST);
        queue_byte(HASH_BYTE);
        queue_byte(START_BYTE);
        queue_byte(HASH_BYTE);
        queue_byte(8'("c"));
        queue_byte(8'("0") + 8'(s[3:0]));
        // empty packet, non-hex and zero digits read as 0
        queue_byte(START_BYTE);
        queue_byte(HASH_BYTE);
        queue_byte(8'("z"));
        queue_byte(8'h00);
        // nack, '$' as a checksum digit
        queue_byte(START_BYTE);
        queue_byte(8'("A"));
        queue_byte(HASH_BYTE);
        queue_byte(8'("G"));
        queue_byte(START_BYTE);
        // upper-case digits
        queue_byte(START_BYTE);
        queue_byte(8'hAB);
        queue_byte(HASH_BYTE);
        queue_byte(8'("A"));
        queue_byte(8'("B"));
        drain();

        // payload full, '#' as the overflowing byte, then a short packet
        send_packet(PAYLOAD_CAP, 0, 1'b0, 1'b0);
        queue_byte(HASH_BYTE);
        send_packet(4, 0, 1'b0, 1'b1);

        write_escape(8'h00);
        random_traffic(35);
        write_escape(8'hFF);
        random_traffic(35);
        write_escape(HASH_BYTE);
        send_packet(3, 50, 1'b0, 1'b1);
        random_traffic(30);
        write_escape(START_BYTE);
        random_traffic(35);
        write_escape(8'($urandom_range(0, 255)));
        random_traffic(35);
        write_escape(ESCAPE_RST);
        random_traffic(35);

        drain();
        repeat (20) @(negedge clk);
        $display("Covered %0d bytes over %0d escape settings incl. a payload-full packet.",
                 bytes_accepted, escape_writes);
        $display("Checked %0d payload, %0d ack, %0d nack, %0d overflow items; %0d mismatches.",
                 status_seen[ST_DATA], status_seen[ST_ACK], status_seen[ST_NACK],
                 status_seen[ST_OVERFLOW], mismatches);
        if (mismatches == 0 && expected_results.size() == 0)
        begin
            $display("[debug_packet_receiver_unit] OK");
        end
        else
        begin
            $display("[debug_packet_receiver_unit] ERROR");
        end
        $finish;
    end

    initial
    begin : watchdog
        #(TIMEOUT_NS);
        $display("Timed out with %0d results outstanding", expected_results.size());
        $display("[debug_packet_receiver_unit] ERROR");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/dpr_pkg.sv
hw/rtl/dpr_decode.sv
hw/rtl/debug_packet_receiver_unit.sv
hw/rtl/dpr_checker.sv
bench/debug_packet_receiver_unit_tb.sv
